// ===== rtl/ansi_sgr_cell_encoder_defines.svh =====
// assertion macros for the sgr cell encoder
`ifndef ANSI_SGR_CELL_ENCODER_DEFINES_SVH
`define ANSI_SGR_CELL_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define ASCE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("asce assertion failed");
`define ASCE_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("asce forbidden condition");
`else
`define ASCE_ASSERT(label, clk, rst, prop)
`define ASCE_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/asce_pkg.sv =====
// shared types and constants of the sgr cell encoder
`timescale 1ns / 1ps
package asce_pkg;
  localparam int NUM_SLOTS = 13;
  localparam int SLOT_W = 4;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef struct packed {
    logic                          seq;
    logic [NUM_SLOTS-1:0]          mask;
    logic [NUM_SLOTS-1:0][7:0]     pval;
    logic [2:0]                    ucnt;
    logic [3:0][7:0]               ubyte;
  } job_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_LBR,
    PH_PARAM,
    PH_M,
    PH_UTF
  } phase_t;

  typedef enum logic [1:0] {
    SUB_SEP,
    SUB_HUN,
    SUB_TEN,
    SUB_ONE
  } sub_t;
endpackage

// ===== rtl/ansi_sgr_cell_encoder.sv =====
// top level of the sgr cell encoder
// Input channel: push/full. A word is a terminal cell (cmd=0: char_code,
// back_color, fore_color, bold_on, underline_on) or an end of line (cmd=1).
// Output channel: empty/pop. Each output word is one byte of the terminal
// stream; last_byte marks the final byte caused by an input word. A word
// that changes nothing and has no valid code point (zero, a surrogate or above 10FFFF) yields no bytes.
// The classifier updates the attribute state at accept and writes a job to
// a QUEUE_DEPTH-entry queue; the serializer drains the queue.
// When the queue is empty, the first job passes through the queue memory and then the output register.
// Throughput: one byte per cycle from the serializer while the receiver pops;
// the serializer spends a step with no byte on the separator of the first
// parameter, on every absent digit of a parameter, and on a job that yields
// no bytes.
// Reset: attributes go to default colors, bold and underline off; queue and
// output register empty. When the receiver stalls, the output holds and the
// queue fills; full rises once it has QUEUE_DEPTH jobs waiting.
`timescale 1ns / 1ps
module ansi_sgr_cell_encoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               cmd,
  input  logic [20:0]        char_code,
  input  logic signed [25:0] back_color,
  input  logic signed [25:0] fore_color,
  input  logic               bold_on,
  input  logic               underline_on,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_byte,
  output logic               last_byte
);
  asce_pkg::job_t wjob, rjob;
  logic accept, rvalid, rpop;

  assign accept = push && !full;

  asce_front u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .cmd(cmd),
    .char_code(char_code),
    .back_color(back_color),
    .fore_color(fore_color),
    .bold_on(bold_on),
    .underline_on(underline_on),
    .job(wjob)
  );

  asce_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(wjob),
    .full(full),
    .pop(rpop),
    .rdata(rjob),
    .valid(rvalid)
  );

  asce_back u_back (
    .clk(clk),
    .rst(rst),
    .job(rjob),
    .job_valid(rvalid),
    .job_pop(rpop),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .last_byte(last_byte)
  );
endmodule

// ===== rtl/asce_queue.sv =====
// job queue between the classifier and the byte serializer
`timescale 1ns / 1ps
module asce_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  asce_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output asce_pkg::job_t rdata,
  output logic          valid
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  asce_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && valid) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && valid);
    end
  end
endmodule

// ===== rtl/asce_front.sv =====
// classifier: tracks terminal attributes and builds one job per word
`timescale 1ns / 1ps
module asce_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic                cmd,
  input  logic [20:0]         char_code,
  input  logic signed [25:0]  back_color,
  input  logic signed [25:0]  fore_color,
  input  logic                bold_on,
  input  logic                underline_on,
  output asce_pkg::job_t      job
);
  localparam logic signed [25:0] COL_DEF    = -26'sd1;
  localparam logic signed [25:0] COL_KEEP   = -26'sd2;
  localparam logic signed [25:0] COL_TRANSP = -26'sd3;
  localparam logic signed [25:0] COL_DEFLT  = -26'sd4;
  localparam logic [20:0] CP_UPPER = 21'h02580;
  localparam logic [20:0] CP_LOWER = 21'h02584;
  localparam logic [20:0] CP_FULL  = 21'h02588;
  localparam logic [20:0] CP_SPACE = 21'h00020;

  logic signed [25:0] cur_back, cur_fore;
  logic cur_bold, cur_underline;
  logic signed [25:0] back_next, fore_next;
  logic bold_next, underline_next;

  logic signed [25:0] bg, fg, bgx, fgx, t, b, td, bd;
  logic signed [25:0] a_bg, a_fg;
  logic a_bold_keep, a_bold, a_ul;
  logic [20:0] a_ch;
  logic lower, do_reset, bg_emit, fg_emit, bold_emit, ul_emit;
  logic signed [25:0] eff_back, eff_fore;
  logic eff_bold, eff_ul;
  logic [44:0] bg_p, fg_p;
  logic [35:0] utf;

  function automatic logic [44:0] add_color(input logic [24:0] c, input logic [7:0] base,
                                            input logic [7:0] bright, input logic [7:0] ext);
    logic [24:0] r;
    logic [4:0] en;
    logic [39:0] v;
    r = c - 25'd256;
    v = '0;
    if (c < 25'd8) begin
      en = 5'b00001;
      v[7:0] = base + c[7:0];
    end else if (c < 25'd16) begin
      en = 5'b00001;
      v[7:0] = bright + c[7:0] - 8'd8;
    end else if (c < 25'd256) begin
      en = 5'b00111;
      v[23:0] = {c[7:0], 8'd5, ext};
    end else begin
      en = 5'b11111;
      v = {r[7:0], r[15:8], r[23:16], 8'd2, ext};
    end
    return {en, v};
  endfunction

  // count in [34:32], bytes low first
  function automatic logic [35:0] utf8(input logic [20:0] c);
    logic [2:0] n;
    logic [31:0] v;
    v = '0;
    if (c == '0 || c > 21'h10FFFF || (c >= 21'h0D800 && c <= 21'h0DFFF)) begin
      n = 3'd0;
    end else if (c < 21'h80) begin
      n = 3'd1;
      v[7:0] = c[7:0];
    end else if (c < 21'h800) begin
      n = 3'd2;
      v[15:0] = {2'b10, c[5:0], 3'b110, c[10:6]};
    end else if (c < 21'h10000) begin
      n = 3'd3;
      v[23:0] = {2'b10, c[5:0], 2'b10, c[11:6], 4'b1110, c[15:12]};
    end else begin
      n = 3'd4;
      v = {2'b10, c[5:0], 2'b10, c[11:6], 2'b10, c[17:12], 5'b11110, c[20:18]};
    end
    return {1'b0, n, v};
  endfunction

  always_comb begin
    bg = back_color[25] ? COL_DEF : back_color;
    fg = fore_color[25] ? COL_DEF : fore_color;
    lower = (char_code == CP_LOWER);
    bgx = (bg == COL_DEF) ? COL_TRANSP : bg;
    fgx = (fg == COL_DEF) ? COL_DEFLT : fg;
    t = lower ? bgx : fgx;
    b = lower ? fgx : bgx;
    td = t[25] ? COL_DEF : t;
    bd = b[25] ? COL_DEF : b;
    a_bold_keep = 1'b0;
    a_bold = bold_on;
    a_ul = underline_on;
    a_bg = bg;
    a_fg = fg;
    a_ch = char_code;
    if (char_code == CP_LOWER || char_code == CP_UPPER) begin
      priority if (t == COL_TRANSP) begin
        a_bg = COL_DEF; a_fg = bd; a_ch = CP_LOWER;
      end else if (b == COL_TRANSP) begin
        a_bg = COL_DEF; a_fg = td; a_ch = CP_UPPER;
      end else if (t == COL_DEFLT) begin
        a_bg = bd; a_fg = COL_DEF; a_ch = CP_UPPER;
      end else if (b == COL_DEFLT) begin
        a_bg = td; a_fg = COL_DEF; a_ch = CP_LOWER;
      end else if (b == t && cur_back == b) begin
        a_bg = COL_KEEP; a_fg = COL_KEEP; a_ch = CP_SPACE;
      end else if (b == t && cur_fore == b) begin
        a_bg = COL_KEEP; a_fg = COL_KEEP; a_ch = CP_FULL;
      end else if (b == t) begin
        a_bg = b; a_fg = COL_KEEP; a_ch = CP_SPACE;
      end else if (cur_back == b || cur_fore == t) begin
        a_bg = b; a_fg = t; a_ch = CP_UPPER;
      end else begin
        a_bg = t; a_fg = b; a_ch = CP_LOWER;
      end
    end else if (char_code == CP_FULL) begin
      if (fg != COL_DEF) begin
        a_bg = fg; a_fg = COL_KEEP; a_ch = CP_SPACE;
      end else begin
        a_bg = COL_KEEP; a_fg = COL_DEF; a_ch = CP_FULL;
      end
    end else if (char_code == CP_SPACE) begin
      a_fg = COL_KEEP;
      a_bold_keep = 1'b1;
    end

    do_reset = (a_fg == COL_DEF && cur_fore != COL_DEF) ||
               (a_bg == COL_DEF && cur_back != COL_DEF);
    eff_back = do_reset ? COL_DEF : cur_back;
    eff_fore = do_reset ? COL_DEF : cur_fore;
    eff_bold = do_reset ? 1'b0 : cur_bold;
    eff_ul   = do_reset ? 1'b0 : cur_underline;
    bg_emit = (a_bg != COL_KEEP) && (a_bg != eff_back);
    fg_emit = (a_fg != COL_KEEP) && (a_fg != eff_fore);
    bold_emit = !a_bold_keep && (a_bold != eff_bold);
    ul_emit = (a_ul != eff_ul);
    bg_p = add_color(a_bg[24:0], 8'd40, 8'd100, 8'd48);
    fg_p = add_color(a_fg[24:0], 8'd30, 8'd90, 8'd38);
    utf = utf8(a_ch);

    back_next = (a_bg != COL_KEEP) ? a_bg : eff_back;
    fore_next = (a_fg != COL_KEEP) ? a_fg : eff_fore;
    bold_next = a_bold_keep ? eff_bold : a_bold;
    underline_next = a_ul;

    job.mask = {ul_emit, bold_emit, fg_p[44:40] & {5{fg_emit}},
                bg_p[44:40] & {5{bg_emit}}, do_reset};
    job.pval = {(a_ul ? 8'd4 : 8'd24), (a_bold ? 8'd1 : 8'd22),
                fg_p[39:0], bg_p[39:0], 8'd0};
    job.seq = (job.mask != '0);
    job.ucnt = utf[34:32];
    job.ubyte = utf[31:0];

    if (cmd) begin
      back_next = COL_DEF;
      fore_next = COL_DEF;
      bold_next = 1'b0;
      underline_next = cur_underline;
      job.mask = '0;
      job.seq = 1'b1;
      job.ucnt = 3'd1;
      job.ubyte = {24'd0, asce_pkg::CH_LF};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_back <= COL_DEF;
      cur_fore <= COL_DEF;
      cur_bold <= 1'b0;
      cur_underline <= 1'b0;
    end else if (accept) begin
      cur_back <= back_next;
      cur_fore <= fore_next;
      cur_bold <= bold_next;
      cur_underline <= underline_next;
    end
  end
endmodule

// ===== rtl/asce_back.sv =====
// serializer: walks a job, up to one byte per cycle into the output register when not stalled
`timescale 1ns / 1ps
`include "ansi_sgr_cell_encoder_defines.svh"
module asce_back (
  input  logic           clk,
  input  logic           rst,
  input  asce_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           last_byte
);
  localparam int NS = asce_pkg::NUM_SLOTS;
  localparam int SW = asce_pkg::SLOT_W;

  asce_pkg::phase_t phase, phase_next;
  asce_pkg::sub_t sub, sub_next;
  logic [SW-1:0] slot, slot_next;
  logic [1:0] uidx, uidx_next;
  logic first, first_next;
  logic oval;
  logic advance, emit, lastb, done, more;
  logic [7:0] byte_val, v;
  logic [SW-1:0] nslot;
  logic [SW:0] first_slot;
  logic [1:0] dh;
  logic [3:0] dt, dn;

  function automatic logic [SW:0] find_slot(input logic [NS-1:0] m, input logic [SW:0] from);
    logic [SW:0] r;
    r = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (m[i] && (SW+1)'(i) >= from) begin
        r = {1'b1, SW'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic [9:0] digits(input logic [7:0] x);
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] tn;
    logic [7:0] o;
    h = (x >= 8'd200) ? 2'd2 : (x >= 8'd100) ? 2'd1 : 2'd0;
    r = x - ((h == 2'd2) ? 8'd200 : (h == 2'd1) ? 8'd100 : 8'd0);
    tn = '0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 8'(10 * i)) begin
        tn = 4'(i);
      end
    end
    o = r - {tn, 3'b000} - {3'b000, tn, 1'b0};
    return {h, tn, o[3:0]};
  endfunction

  assign advance = !oval || pop;
  assign empty = !oval;
  assign job_pop = done;

  always_comb begin
    emit = 1'b0;
    lastb = 1'b0;
    done = 1'b0;
    byte_val = '0;
    phase_next = phase;
    sub_next = sub;
    slot_next = slot;
    uidx_next = uidx;
    first_next = first;
    v = job.pval[slot];
    {dh, dt, dn} = digits(v);
    {more, nslot} = find_slot(job.mask, {1'b0, slot} + 1'b1);
    first_slot = find_slot(job.mask, '0);
    if (job_valid && advance) begin
      unique case (phase)
        asce_pkg::PH_START: begin
          if (job.seq) begin
            emit = 1'b1;
            byte_val = asce_pkg::CH_ESC;
            phase_next = asce_pkg::PH_LBR;
          end else if (job.ucnt != '0) begin
            emit = 1'b1;
            byte_val = job.ubyte[0];
            lastb = (job.ucnt == 3'd1);
            done = lastb;
            phase_next = asce_pkg::PH_UTF;
            uidx_next = 2'd1;
          end else begin
            done = 1'b1;
          end
        end
        asce_pkg::PH_LBR: begin
          emit = 1'b1;
          byte_val = asce_pkg::CH_LBR;
          if (job.mask != '0) begin
            phase_next = asce_pkg::PH_PARAM;
            slot_next = first_slot[SW-1:0];
            sub_next = asce_pkg::SUB_SEP;
            first_next = 1'b1;
          end else begin
            phase_next = asce_pkg::PH_M;
          end
        end
        asce_pkg::PH_PARAM: begin
          unique case (sub)
            asce_pkg::SUB_SEP: begin
              emit = !first;
              byte_val = asce_pkg::CH_SEMI;
              sub_next = asce_pkg::SUB_HUN;
            end
            asce_pkg::SUB_HUN: begin
              emit = (v >= 8'd100);
              byte_val = asce_pkg::CH_ZERO + {6'd0, dh};
              sub_next = asce_pkg::SUB_TEN;
            end
            asce_pkg::SUB_TEN: begin
              emit = (v >= 8'd10);
              byte_val = asce_pkg::CH_ZERO + {4'd0, dt};
              sub_next = asce_pkg::SUB_ONE;
            end
            asce_pkg::SUB_ONE: begin
              emit = (v != 8'd0);
              byte_val = asce_pkg::CH_ZERO + {4'd0, dn};
              first_next = 1'b0;
              sub_next = asce_pkg::SUB_SEP;
              if (more) begin
                slot_next = nslot;
              end else begin
                phase_next = asce_pkg::PH_M;
              end
            end
            default: ;
          endcase
        end
        asce_pkg::PH_M: begin
          emit = 1'b1;
          byte_val = asce_pkg::CH_M;
          lastb = (job.ucnt == '0);
          done = lastb;
          phase_next = asce_pkg::PH_UTF;
          uidx_next = 2'd0;
        end
        asce_pkg::PH_UTF: begin
          emit = 1'b1;
          byte_val = job.ubyte[uidx];
          lastb = ({1'b0, uidx} + 3'd1 == job.ucnt);
          done = lastb;
          uidx_next = uidx + 2'd1;
        end
        default: ;
      endcase
    end
    if (done) begin
      phase_next = asce_pkg::PH_START;
      uidx_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= asce_pkg::PH_START;
      sub <= asce_pkg::SUB_SEP;
      slot <= '0;
      uidx <= '0;
      first <= 1'b1;
      oval <= 1'b0;
    end else begin
      phase <= phase_next;
      sub <= sub_next;
      slot <= slot_next;
      uidx <= uidx_next;
      first <= first_next;
      if (advance) begin
        oval <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= byte_val;
      last_byte <= lastb;
    end
  end

  `ASCE_ASSERT(a_job_present, clk, rst, (phase != asce_pkg::PH_START) |-> job_valid)
  `ASCE_ASSERT(a_utf_index, clk, rst, (phase == asce_pkg::PH_UTF) |-> ({1'b0, uidx} < job.ucnt))
  `ASCE_ASSERT(a_last_restarts, clk, rst, (emit && lastb) |=> (phase == asce_pkg::PH_START))
  `ASCE_ASSERT_NEVER(a_pop_without_job, clk, rst, job_pop && !job_valid)
endmodule

// ===== bench/ansi_sgr_cell_encoder_test.sv =====
// self-checking bench for the sgr cell encoder with a byte-stream predictor
`timescale 1ns / 1ps
module ansi_sgr_cell_encoder_test;
  localparam int KEEP = -2;
  localparam int TRANSP = -3;
  localparam int DEFLT = -4;
  localparam int CP_UPPER = 'h2580;
  localparam int CP_LOWER = 'h2584;
  localparam int CP_FULL = 'h2588;
  localparam int CP_SPACE = 'h20;
  localparam int CMD_CELL = 0;
  localparam int CMD_EOL = 1;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic        cmd;
    logic [20:0] ch;
    logic [25:0] bg;
    logic [25:0] fg;
    logic        bold;
    logic        ul;
  } cell_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } byte_t;

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0;
  logic cmd = 0, bold_on = 0, underline_on = 0;
  logic [20:0] char_code = 0;
  logic signed [25:0] back_color = 0, fore_color = 0;
  logic full, empty, last_byte;
  logic [7:0] out_byte;

  ansi_sgr_cell_encoder uut (.*);

  cell_t pending[$];
  byte_t stream_expected[$];
  int term_back, term_fore;
  bit term_bold, term_ul;
  byte unsigned sbuf[$];
  int errors = 0, cycles = 0;
  bit done = 0, quiet = 0;

  initial forever #6 clk = ~clk;

  function automatic int color_of(logic [25:0] v);
    int s;
    s = $signed(v);
    return s < 0 ? -1 : s;
  endfunction

  function automatic void put_byte(int v);
    sbuf.insert(sbuf.size(), 8'(v));
  endfunction

  function automatic void add_param(ref int p[$], input int v);
    p.insert(p.size(), v);
  endfunction

  function automatic void queue_cell(cell_t c);
    pending.insert(pending.size(), c);
  endfunction

  function automatic void put_dec(int v);
    if (v >= 100) put_byte(8'h30 + v / 100);
    if (v >= 10) put_byte(8'h30 + (v / 10) % 10);
    if (v != 0) put_byte(8'h30 + v % 10);
  endfunction

  function automatic void add_color(ref int p[$], input int c, int base, int bright, int ext);
    int r;
    if (c < 8) add_param(p, base + c);
    else if (c < 16) add_param(p, bright + c - 8);
    else if (c < 256) begin
      add_param(p, ext); add_param(p, 5); add_param(p, c);
    end else begin
      r = c - 256;
      add_param(p, ext); add_param(p, 2);
      add_param(p, (r >> 16) & 'hff); add_param(p, (r >> 8) & 'hff); add_param(p, r & 'hff);
    end
  endfunction

  function automatic void put_utf8(int c);
    if (c == 0 || c > 'h10ffff || (c >= 'hd800 && c <= 'hdfff)) return;
    if (c < 'h80) put_byte(c);
    else if (c < 'h800) begin
      put_byte('hc0 | (c >> 6)); put_byte('h80 | (c & 'h3f));
    end else if (c < 'h10000) begin
      put_byte('he0 | (c >> 12)); put_byte('h80 | ((c >> 6) & 'h3f));
      put_byte('h80 | (c & 'h3f));
    end else begin
      put_byte('hf0 | (c >> 18)); put_byte('h80 | ((c >> 12) & 'h3f));
      put_byte('h80 | ((c >> 6) & 'h3f)); put_byte('h80 | (c & 'h3f));
    end
  endfunction

  function automatic void draw(int bg, int fg, int bold, bit ul, int ch);
    int p[$];
    if ((fg == -1 && term_fore != -1) || (bg == -1 && term_back != -1)) begin
      add_param(p, 0);
      term_fore = -1; term_back = -1; term_bold = 0; term_ul = 0;
    end
    if (bg != KEEP && bg != term_back) add_color(p, bg, 40, 100, 48);
    if (fg != KEEP && fg != term_fore) add_color(p, fg, 30, 90, 38);
    if (bold >= 0 && (bold != 0) != term_bold) add_param(p, bold ? 1 : 22);
    if (ul != term_ul) add_param(p, ul ? 4 : 24);
    if (p.size() > 0) begin
      put_byte(8'h1b); put_byte(8'h5b);
      foreach (p[i]) begin
        if (i > 0) put_byte(8'h3b);
        put_dec(p[i]);
      end
      put_byte(8'h6d);
    end
    put_utf8(ch);
    if (bg != KEEP) term_back = bg;
    if (fg != KEEP) term_fore = fg;
    if (bold >= 0) term_bold = bold != 0;
    term_ul = ul;
  endfunction

  function automatic void draw_half(int ch, int bg, int fg, int bold, bit ul);
    int bgx, fgx, t, b, td, bd;
    bgx = bg == -1 ? TRANSP : bg;
    fgx = fg == -1 ? DEFLT : fg;
    t = ch == CP_LOWER ? bgx : fgx;
    b = ch == CP_LOWER ? fgx : bgx;
    td = t >= 0 ? t : -1;
    bd = b >= 0 ? b : -1;
    if (t == TRANSP) draw(-1, bd, bold, ul, CP_LOWER);
    else if (b == TRANSP) draw(-1, td, bold, ul, CP_UPPER);
    else if (t == DEFLT) draw(bd, -1, bold, ul, CP_UPPER);
    else if (b == DEFLT) draw(td, -1, bold, ul, CP_LOWER);
    else if (b == t && term_back == b) draw(KEEP, KEEP, bold, ul, CP_SPACE);
    else if (b == t && term_fore == b) draw(KEEP, KEEP, bold, ul, CP_FULL);
    else if (b == t) draw(b, KEEP, bold, ul, CP_SPACE);
    else if (term_back == b || term_fore == t) draw(b, t, bold, ul, CP_UPPER);
    else draw(t, b, bold, ul, CP_LOWER);
  endfunction

  function automatic void predict_bytes(cell_t c);
    int bg, fg, ch;
    byte_t e;
    sbuf.delete();
    ch = c.ch;
    bg = color_of(c.bg);
    fg = color_of(c.fg);
    if (c.cmd == CMD_EOL) begin
      term_fore = -1; term_back = -1; term_bold = 0;
      sbuf = '{8'h1b, 8'h5b, 8'h6d, 8'h0a};
    end else if (ch == CP_LOWER || ch == CP_UPPER) draw_half(ch, bg, fg, c.bold, c.ul);
    else if (ch == CP_FULL) begin
      if (fg != -1) draw(fg, KEEP, c.bold, c.ul, CP_SPACE);
      else draw(KEEP, -1, c.bold, c.ul, CP_FULL);
    end else if (ch == CP_SPACE) draw(bg, KEEP, -1, c.ul, ch);
    else draw(bg, fg, c.bold, c.ul, ch);
    while (sbuf.size() > 48) void'(sbuf.pop_back());
    foreach (sbuf[i]) begin
      e.b = sbuf[i];
      e.last = i == sbuf.size() - 1;
      stream_expected.insert(stream_expected.size(), e);
    end
  endfunction

  function automatic logic [25:0] rand_color();
    case ($urandom_range(0, 9))
      0: return -1;
      1: return $urandom_range(0, 7);
      2: return $urandom_range(8, 15);
      3: return $urandom_range(16, 255);
      4: return 256 + $urandom_range(0, 'hffffff);
      5: return $urandom;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [20:0] rand_char();
    case ($urandom_range(0, 11))
      0: return CP_UPPER;
      1: return CP_LOWER;
      2: return CP_FULL;
      3: return CP_SPACE;
      4: return $urandom_range('h80, 'h7ff);
      5: return $urandom_range('h800, 'hffff);
      6: return $urandom_range('h10000, 'h10ffff);
      7: return $urandom;
      8: return $urandom_range('hd800, 'hdfff);
      default: return $urandom_range(0, 'h7f);
    endcase
  endfunction

  function automatic cell_t mk(logic c, logic [20:0] ch, logic [25:0] bg, logic [25:0] fg,
                               logic b, logic u);
    cell_t x;
    x = '{c, ch, bg, fg, b, u};
    return x;
  endfunction

  initial begin
    cell_t x;
    queue_cell(mk(CMD_CELL, 'h41, 0, 7, 1, 1));
    queue_cell(mk(CMD_CELL, 'h41, 0, 7, 1, 1));
    queue_cell(mk(CMD_CELL, 0, 8, 15, 0, 0));
    queue_cell(mk(CMD_CELL, 'h1fffff, 255, 16, 1, 0));
    queue_cell(mk(CMD_CELL, 'hd800, 256, 26'h1ffffff, 0, 1));
    queue_cell(mk(CMD_CELL, 'h10ffff, 26'h2000000, -1, 1, 1));
    queue_cell(mk(CMD_CELL, 'h7ff, 26'h1ffffff, 256 + 'hffffff, 0, 0));
    queue_cell(mk(CMD_CELL, CP_SPACE, 3, -1, 1, 1));
    queue_cell(mk(CMD_CELL, CP_UPPER, 5, 5, 0, 0));
    queue_cell(mk(CMD_CELL, CP_LOWER, 5, 5, 0, 0));
    queue_cell(mk(CMD_CELL, CP_LOWER, -1, 9, 1, 0));
    queue_cell(mk(CMD_CELL, CP_UPPER, 2, -1, 1, 0));
    queue_cell(mk(CMD_CELL, CP_UPPER, 2, 3, 0, 1));
    queue_cell(mk(CMD_CELL, CP_LOWER, 2, 3, 0, 1));
    queue_cell(mk(CMD_CELL, CP_FULL, 1, 4, 1, 1));
    queue_cell(mk(CMD_CELL, CP_FULL, 1, -1, 1, 1));
    queue_cell(mk(CMD_EOL, 'h1fffff, -1, -1, 1, 1));
    queue_cell(mk(CMD_CELL, 'h2603, 300, 1000, 0, 1));
    queue_cell(mk(CMD_EOL, 0, 0, 0, 0, 0));
    repeat (480) begin
      x.cmd = $urandom_range(0, 11) == 0 ? CMD_EOL : CMD_CELL;
      x.ch = rand_char();
      x.bg = rand_color();
      x.fg = $urandom_range(0, 2) == 0 ? x.bg : rand_color();
      x.bold = $urandom;
      x.ul = $urandom;
      queue_cell(x);
    end
  end

  function automatic bit idle_now();
    return !quiet && $urandom_range(0, 99) < 38;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    quiet <= cycles % 3000 >= 2000 && cycles % 3000 < 2600;
    if (rst) begin
      push <= 0;
      pop <= 0;
      term_back = -1; term_fore = -1; term_bold = 0; term_ul = 0;
    end else begin
      if (push && !full) begin
        predict_bytes(pending.pop_front());
      end
      if (pop && !empty) begin
        if (stream_expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h last %b", out_byte, last_byte);
        end else begin
          byte_t e;
          e = stream_expected.pop_front();
          if (e.b !== out_byte || e.last !== last_byte) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h/%b got %h/%b", e.b, e.last, out_byte, last_byte);
          end
        end
      end
      if (pending.size() > 0 && !idle_now() && !done) begin
        push <= 1;
        {cmd, char_code, back_color, fore_color, bold_on, underline_on} <= pending[0];
      end else begin
        push <= 0;
      end
      pop <= !idle_now();
    end
  end

  // avoid re-pushing the head item before the acceptance is recorded
  always @(negedge clk) if (push && !full) done <= pending.size() <= 1;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    fork
      begin
        wait (pending.size() == 0 && !push);
        wait (stream_expected.size() == 0);
        repeat (80) @(posedge clk);
        if (errors == 0 && stream_expected.size() == 0)
          $display("ansi_sgr_cell_encoder_test: PASS");
        else
          $display("ansi_sgr_cell_encoder_test: FAIL");
      end
      begin
        wait (cycles >= LIMIT);
        $display("ansi_sgr_cell_encoder_test: FAIL");
      end
    join_any
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/asce_pkg.sv
rtl/asce_queue.sv
rtl/asce_front.sv
rtl/asce_back.sv
rtl/ansi_sgr_cell_encoder.sv
bench/ansi_sgr_cell_encoder_test.sv
